@@ design/enhanced_clock_page_replacer_assert.svh @@
// Assertion macros shared by the page replacer RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef ENHANCED_CLOCK_PAGE_REPLACER_ASSERT_SVH
`define ENHANCED_CLOCK_PAGE_REPLACER_ASSERT_SVH

// same-cycle implication
`define ECPR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ecpr check failed");

// next-cycle implication
`define ECPR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ecpr check failed");

`endif

@@ design/ecpr_pkg.sv @@
// Shared constants and types for the enhanced clock page replacer.
// No dependencies.
package ecpr_pkg;

	localparam int FRAMES_DEFAULT     = 8;
	localparam int PAGE_BITS_DEFAULT  = 8;
	localparam int COUNT_BITS_DEFAULT = 16;

	localparam int CFG_DATA_BITS  = 4;
	localparam int CFG_INDEX_BITS = 1;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAMES_IN_USE = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_PRELOAD_COUNT = 1'd1;

	localparam logic [CFG_DATA_BITS-1:0] FRAMES_IN_USE_RESET = 4'd8;
	localparam logic [CFG_DATA_BITS-1:0] PRELOAD_COUNT_RESET = 4'd0;

	localparam int OUTCOME_BITS = 2;
	localparam logic [OUTCOME_BITS-1:0] OUTCOME_PRELOAD = 2'd0;
	localparam logic [OUTCOME_BITS-1:0] OUTCOME_HIT     = 2'd1;
	localparam logic [OUTCOME_BITS-1:0] OUTCOME_FAULT   = 2'd2;

	localparam logic [1:0] PASS_LAST = 2'd3;

	typedef struct packed {
		logic latch;
		logic eval;
		logic sweep_step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic need_sweep;
		logic sweep_done;
		logic slot_free;
	} status_t;

endpackage

@@ design/ecpr_access_if.sv @@
// Access request channel: page number and write flag.
// Depends on nothing but its parameter.
interface ecpr_access_if #(
	parameter int PAGE_BITS = 8
);
	logic                 valid;
	logic                 ready;
	logic [PAGE_BITS-1:0] page_id;
	logic                 is_write;

	modport source (output valid, output page_id, output is_write, input ready);
	modport sink   (input valid, input page_id, input is_write, output ready);
endinterface

@@ design/ecpr_result_if.sv @@
// Result channel: outcome, frame, eviction and running counts.
// Depends on ecpr_pkg.
interface ecpr_result_if #(
	parameter int FRAME_BITS = 3,
	parameter int PAGE_BITS  = 8,
	parameter int COUNT_BITS = 16
);
	logic                              valid;
	logic                              ready;
	logic [ecpr_pkg::OUTCOME_BITS-1:0] outcome;
	logic [FRAME_BITS-1:0]             frame;
	logic                              evicted_valid;
	logic [PAGE_BITS-1:0]              evicted_page;
	logic [COUNT_BITS-1:0]             fault_count;
	logic [COUNT_BITS-1:0]             access_count;

	modport source (output valid, output outcome, output frame, output evicted_valid,
		output evicted_page, output fault_count, output access_count, input ready);
	modport sink   (input valid, input outcome, input frame, input evicted_valid,
		input evicted_page, input fault_count, input access_count, output ready);
endinterface

@@ design/ecpr_ctrl.sv @@
// Sequencer for the page replacer: accept, evaluate, sweep, commit.
// Depends on ecpr_pkg.
module ecpr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ecpr_pkg::status_t status,
	output ecpr_pkg::cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_EVAL  = 4'b0010,
		ST_SWEEP = 4'b0100,
		ST_WRITE = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.latch = in_valid;
				if (in_valid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = status.need_sweep ? ST_SWEEP : ST_WRITE;
			end
			ST_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (status.sweep_done) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				cmd.commit = status.slot_free;
				if (status.slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ design/ecpr_datapath.sv @@
// Frame table, reference bits, clock hand, sweep engine and result register.
// Depends on ecpr_pkg and enhanced_clock_page_replacer_assert.svh.
`include "enhanced_clock_page_replacer_assert.svh"

module ecpr_datapath #(
	parameter int FRAMES     = ecpr_pkg::FRAMES_DEFAULT,
	parameter int PAGE_BITS  = ecpr_pkg::PAGE_BITS_DEFAULT,
	parameter int COUNT_BITS = ecpr_pkg::COUNT_BITS_DEFAULT,
	localparam int HW = $clog2(FRAMES)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ecpr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [ecpr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic [PAGE_BITS-1:0]                in_page,
	input  logic                                in_write,
	input  ecpr_pkg::cmd_t                      cmd,
	output ecpr_pkg::status_t                   status,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ecpr_pkg::OUTCOME_BITS-1:0]   out_outcome,
	output logic [HW-1:0]                       out_frame,
	output logic                                out_evicted_valid,
	output logic [PAGE_BITS-1:0]                out_evicted_page,
	output logic [COUNT_BITS-1:0]               out_fault_count,
	output logic [COUNT_BITS-1:0]               out_access_count
);

	localparam int NW = $clog2(FRAMES + 1);
	localparam int LW = (NW > ecpr_pkg::CFG_DATA_BITS) ? NW : ecpr_pkg::CFG_DATA_BITS;

	logic [ecpr_pkg::CFG_DATA_BITS-1:0] frames_in_use_q, preload_count_q;
	logic [PAGE_BITS-1:0]               page_q;
	logic                               write_q;
	logic [PAGE_BITS-1:0]               frame_page_q [FRAMES];
	logic [FRAMES-1:0]                  valid_q, acc_q, mod_q;
	logic [NW-1:0]                      filled_q;
	logic [HW-1:0]                      hand_q;
	logic [COUNT_BITS-1:0]              fault_total_q, access_total_q;

	logic [HW-1:0]                      tgt_q;
	logic                               load_q, fault_q, fill_q;
	logic [ecpr_pkg::OUTCOME_BITS-1:0]  outcome_q;
	logic [HW-1:0]                      swp_hand_q, step_q;
	logic [1:0]                         pass_q;

	logic                               rsp_valid_q, rsp_ev_valid_q;
	logic [ecpr_pkg::OUTCOME_BITS-1:0]  rsp_outcome_q;
	logic [HW-1:0]                      rsp_frame_q;
	logic [PAGE_BITS-1:0]               rsp_ev_page_q;

	logic [LW-1:0]     fiu_ext, pre_ext, n_ext, cap_ext;
	logic [NW-1:0]     n;
	logic              preload, free, hit;
	logic [FRAMES-1:0] match;
	logic [HW-1:0]     hit_idx, start_hand, nxt_hand;
	logic              cur_a, cur_m, victim, pass_end, sweep_last;
	logic              ev_valid;

	// live frame count and preload cap
	always_comb begin
		fiu_ext = LW'(frames_in_use_q);
		pre_ext = LW'(preload_count_q);
		if (fiu_ext == '0) begin
			n_ext = LW'(1);
		end else if (fiu_ext > LW'(FRAMES)) begin
			n_ext = LW'(FRAMES);
		end else begin
			n_ext = fiu_ext;
		end
		cap_ext = (pre_ext < n_ext) ? pre_ext : n_ext;
	end

	assign n       = NW'(n_ext);
	assign preload = access_total_q < COUNT_BITS'(cap_ext);
	assign free    = filled_q < n;

	always_comb begin
		for (int i = 0; i < FRAMES; i++) begin
			match[i] = valid_q[i] && (frame_page_q[i] == page_q) && (NW'(i) < n);
		end
	end

	always_comb begin
		hit_idx = '0;
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_idx = HW'(i);
			end
		end
	end

	assign hit        = |match;
	assign start_hand = (NW'(hand_q) < n) ? hand_q : '0;

	assign cur_a      = acc_q[swp_hand_q];
	assign cur_m      = mod_q[swp_hand_q];
	assign victim     = !cur_a && (pass_q[0] ? cur_m : !cur_m);
	assign nxt_hand   = ((NW'(swp_hand_q) + NW'(1)) == n) ? '0 : swp_hand_q + HW'(1);
	assign pass_end   = NW'(step_q) == (n - NW'(1));
	assign sweep_last = (pass_q == ecpr_pkg::PASS_LAST) && pass_end;

	assign ev_valid   = load_q && valid_q[tgt_q];

	assign status.need_sweep = !hit && !free;
	assign status.sweep_done = victim || sweep_last;
	assign status.slot_free  = !rsp_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= ecpr_pkg::FRAMES_IN_USE_RESET;
			preload_count_q <= ecpr_pkg::PRELOAD_COUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ecpr_pkg::CFG_FRAMES_IN_USE: frames_in_use_q <= cfg_data;
				ecpr_pkg::CFG_PRELOAD_COUNT: preload_count_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			page_q  <= in_page;
			write_q <= in_write;
		end
		if (cmd.commit && load_q) begin
			frame_page_q[tgt_q] <= page_q;
		end
	end

	// decision and sweep registers
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			swp_hand_q <= start_hand;
			pass_q     <= '0;
			step_q     <= '0;
			if (preload && hit) begin
				tgt_q <= hit_idx; load_q <= 1'b0; fill_q <= 1'b0; fault_q <= 1'b0;
				outcome_q <= ecpr_pkg::OUTCOME_PRELOAD;
			end else if (preload && free) begin
				tgt_q <= HW'(filled_q); load_q <= 1'b1; fill_q <= 1'b1; fault_q <= 1'b0;
				outcome_q <= ecpr_pkg::OUTCOME_PRELOAD;
			end else if (hit) begin
				tgt_q <= hit_idx; load_q <= 1'b0; fill_q <= 1'b0; fault_q <= 1'b0;
				outcome_q <= ecpr_pkg::OUTCOME_HIT;
			end else begin
				tgt_q <= HW'(filled_q); load_q <= 1'b1; fill_q <= free; fault_q <= 1'b1;
				outcome_q <= ecpr_pkg::OUTCOME_FAULT;
			end
		end else if (cmd.sweep_step) begin
			if (victim) begin
				tgt_q <= swp_hand_q;
			end else begin
				swp_hand_q <= nxt_hand;
				if (pass_end) begin
					step_q <= '0;
					pass_q <= pass_q + 2'd1;
				end else begin
					step_q <= step_q + HW'(1);
				end
				if (sweep_last) begin
					tgt_q <= nxt_hand;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q        <= '0;
			acc_q          <= '0;
			mod_q          <= '0;
			filled_q       <= '0;
			hand_q         <= '0;
			fault_total_q  <= '0;
			access_total_q <= '0;
		end else if (cmd.sweep_step) begin
			if (!victim && pass_q[0]) begin
				acc_q[swp_hand_q] <= 1'b0;
			end
		end else if (cmd.commit) begin
			acc_q[tgt_q] <= 1'b1;
			if (load_q) begin
				valid_q[tgt_q] <= 1'b1;
				mod_q[tgt_q]   <= write_q;
			end else if (write_q) begin
				mod_q[tgt_q] <= 1'b1;
			end
			if (fill_q) begin
				filled_q <= filled_q + NW'(1);
			end
			if (fault_q) begin
				hand_q <= tgt_q;
				if (fault_total_q != '1) begin
					fault_total_q <= fault_total_q + COUNT_BITS'(1);
				end
			end
			if (access_total_q != '1) begin
				access_total_q <= access_total_q + COUNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (out_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_outcome_q  <= outcome_q;
			rsp_frame_q    <= tgt_q;
			rsp_ev_valid_q <= ev_valid;
			rsp_ev_page_q  <= ev_valid ? frame_page_q[tgt_q] : '0;
		end
	end

	assign out_valid         = rsp_valid_q;
	assign out_outcome       = rsp_outcome_q;
	assign out_frame         = rsp_frame_q;
	assign out_evicted_valid = rsp_ev_valid_q;
	assign out_evicted_page  = rsp_ev_page_q;
	assign out_fault_count   = fault_total_q;
	assign out_access_count  = access_total_q;

	`ECPR_ASSERT_NOW(a_load_in_range, cmd.commit && load_q, NW'(tgt_q) < n)
	`ECPR_ASSERT_NOW(a_sweep_only_full, cmd.sweep_step, filled_q >= n)
	`ECPR_ASSERT_NOW(a_faults_le_access, 1'b1, fault_total_q <= access_total_q)
	`ECPR_ASSERT_NEXT(a_commit_shows, cmd.commit, rsp_valid_q && (rsp_frame_q == $past(tgt_q)))

endmodule

@@ design/enhanced_clock_page_replacer.sv @@
// Channel     | dir | payload
// access      | in  | page_id, is_write
// result      | out | outcome, frame, evicted_valid, evicted_page, fault_count, access_count
// cfg_*       | in  | register index and data, write only
// A preload or hit goes from accept to result through latch, lookup and commit.
// A fault with no free frame also runs the sweep, which moves the clock hand
// one frame per step, for up to four passes over the live frames.
// One access is in flight at a time; a new one is taken while the result waits.
// Reset is asynchronous and clears all frame bits and counters at once.
module enhanced_clock_page_replacer #(
	parameter int FRAMES     = ecpr_pkg::FRAMES_DEFAULT,
	parameter int PAGE_BITS  = ecpr_pkg::PAGE_BITS_DEFAULT,
	parameter int COUNT_BITS = ecpr_pkg::COUNT_BITS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ecpr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [ecpr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	ecpr_access_if.sink                         access,
	ecpr_result_if.source                       result
);

	ecpr_pkg::cmd_t    cmd;
	ecpr_pkg::status_t status;
	logic              in_ready;

	ecpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (access.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	assign access.ready = in_ready;

	ecpr_datapath #(
		.FRAMES     (FRAMES),
		.PAGE_BITS  (PAGE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_page           (access.page_id),
		.in_write          (access.is_write),
		.cmd               (cmd),
		.status            (status),
		.out_valid         (result.valid),
		.out_ready         (result.ready),
		.out_outcome       (result.outcome),
		.out_frame         (result.frame),
		.out_evicted_valid (result.evicted_valid),
		.out_evicted_page  (result.evicted_page),
		.out_fault_count   (result.fault_count),
		.out_access_count  (result.access_count)
	);

endmodule

@@ verif/enhanced_clock_page_replacer_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the enhanced clock page replacer: directed table, then random page
// streams over many frame and preload settings with ready gaps, a long hold-off and a drain.
// Depends on ecpr_pkg, the two channel interfaces and the top module of the design.
module enhanced_clock_page_replacer_tb;

	localparam int FRAMES      = 8;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic [ecpr_pkg::OUTCOME_BITS-1:0] outcome;
		logic [2:0]                        frame;
		logic                              ev_valid;
		logic [7:0]                        ev_page;
		logic [15:0]                       faults;
		logic [15:0]                       accesses;
	} access_result_t;

	typedef enum logic [1:0] {ROW_ACCESS, ROW_SET_FRAMES, ROW_SET_PRELOAD} row_kind_t;

	typedef struct packed {
		row_kind_t      kind;
		logic [7:0]     val;
		logic           wr;
		logic           fixed;
		access_result_t want;
	} row_t;

	localparam row_t DIR_ROWS [24] = '{
		'{ROW_SET_PRELOAD, 8'd3, 1'b0, 1'b0, '0},
		'{ROW_SET_FRAMES,  8'd4, 1'b0, 1'b0, '0},
		'{ROW_ACCESS, 8'h00, 1'b0, 1'b1,
			'{ecpr_pkg::OUTCOME_PRELOAD, 3'd0, 1'b0, 8'h00, 16'd0, 16'd1}},
		'{ROW_ACCESS, 8'hFF, 1'b1, 1'b1,
			'{ecpr_pkg::OUTCOME_PRELOAD, 3'd1, 1'b0, 8'h00, 16'd0, 16'd2}},
		'{ROW_ACCESS, 8'h00, 1'b1, 1'b1,
			'{ecpr_pkg::OUTCOME_PRELOAD, 3'd0, 1'b0, 8'h00, 16'd0, 16'd3}},
		'{ROW_ACCESS, 8'hFF, 1'b0, 1'b1,
			'{ecpr_pkg::OUTCOME_HIT,     3'd1, 1'b0, 8'h00, 16'd0, 16'd4}},
		'{ROW_ACCESS, 8'h10, 1'b0, 1'b1,
			'{ecpr_pkg::OUTCOME_FAULT,   3'd2, 1'b0, 8'h00, 16'd1, 16'd5}},
		'{ROW_ACCESS, 8'h20, 1'b1, 1'b1,
			'{ecpr_pkg::OUTCOME_FAULT,   3'd3, 1'b0, 8'h00, 16'd2, 16'd6}},
		'{ROW_ACCESS, 8'h30, 1'b0, 1'b0, '0},
		'{ROW_ACCESS, 8'h10, 1'b1, 1'b0, '0},
		'{ROW_SET_FRAMES,  8'd0, 1'b0, 1'b0, '0},
		'{ROW_ACCESS, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_ACCESS, 8'h55, 1'b1, 1'b0, '0},
		'{ROW_SET_FRAMES,  8'd15, 1'b0, 1'b0, '0},
		'{ROW_ACCESS, 8'hAA, 1'b1, 1'b0, '0},
		'{ROW_ACCESS, 8'h01, 1'b0, 1'b0, '0},
		'{ROW_ACCESS, 8'hFE, 1'b1, 1'b0, '0},
		'{ROW_ACCESS, 8'h7F, 1'b0, 1'b0, '0},
		'{ROW_ACCESS, 8'h80, 1'b1, 1'b0, '0},
		'{ROW_SET_PRELOAD, 8'd15, 1'b0, 1'b0, '0},
		'{ROW_SET_FRAMES,  8'd8, 1'b0, 1'b0, '0},
		'{ROW_ACCESS, 8'h30, 1'b0, 1'b0, '0},
		'{ROW_ACCESS, 8'h66, 1'b1, 1'b0, '0},
		'{ROW_ACCESS, 8'h00, 1'b0, 1'b0, '0}
	};

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                cfg_we;
	logic [ecpr_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [ecpr_pkg::CFG_DATA_BITS-1:0]  cfg_data;

	ecpr_access_if #(.PAGE_BITS(8)) acc_ch ();
	ecpr_result_if #(.FRAME_BITS(3), .PAGE_BITS(8), .COUNT_BITS(16)) res_ch ();

	enhanced_clock_page_replacer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.access    (acc_ch),
		.result    (res_ch)
	);

	// predictor state
	logic [7:0]          frame_pg   [FRAMES];
	logic                frame_live [FRAMES];
	logic                a_bit      [FRAMES];
	logic                m_bit      [FRAMES];
	int                  fill_level;
	int                  hand_pos;
	logic [15:0]         fault_tally;
	logic [15:0]         access_tally;
	logic [3:0]          cfg_frames;
	logic [3:0]          cfg_preload;

	access_result_t      awaited_outcomes [$];
	access_result_t      oldest;
	int                  errors;
	int                  stall_cycles;
	bit                  quiet;
	bit                  hold_req;
	int                  n_pre, n_hit, n_fault, n_evict, n_reg_writes;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int pick_victim(input int n);
		int h;
		h = (hand_pos < n) ? hand_pos : 0;
		for (int sweep_round = 1; sweep_round <= 4; sweep_round++) begin
			for (int s = 0; s < n; s++) begin
				if (sweep_round % 2 == 1) begin
					if (!a_bit[h] && !m_bit[h]) return h;
				end else begin
					if (!a_bit[h] && m_bit[h]) return h;
					a_bit[h] = 1'b0;
				end
				h = (h + 1) % n;
			end
		end
		return h;
	endfunction

	function automatic access_result_t predict_access(input logic [7:0] pg, input logic wr);
		access_result_t r;
		int n, cap, f;
		bit found, pre;
		n = (cfg_frames == 0) ? 1 : ((cfg_frames > FRAMES) ? FRAMES : int'(cfg_frames));
		cap = (cfg_preload < n) ? int'(cfg_preload) : n;
		pre = access_tally < cap;
		found = 1'b0;
		f = 0;
		r = '0;
		for (int i = 0; i < n; i++) begin
			if (!found && frame_live[i] && frame_pg[i] == pg) begin
				found = 1'b1;
				f = i;
			end
		end
		if (found) begin
			a_bit[f] = 1'b1;
			if (wr) m_bit[f] = 1'b1;
			r.outcome = pre ? ecpr_pkg::OUTCOME_PRELOAD : ecpr_pkg::OUTCOME_HIT;
		end else if (pre && fill_level < n) begin
			f = fill_level;
			fill_level++;
			r.outcome = ecpr_pkg::OUTCOME_PRELOAD;
		end else begin
			if (fill_level < n) begin
				f = fill_level;
				fill_level++;
			end else begin
				f = pick_victim(n);
			end
			if (frame_live[f]) begin
				r.ev_valid = 1'b1;
				r.ev_page = frame_pg[f];
			end
			hand_pos = f;
			if (fault_tally != COUNT_MAX) fault_tally++;
			r.outcome = ecpr_pkg::OUTCOME_FAULT;
		end
		if (!found) begin
			frame_pg[f] = pg;
			frame_live[f] = 1'b1;
			a_bit[f] = 1'b1;
			m_bit[f] = wr;
		end
		if (access_tally != COUNT_MAX) access_tally++;
		r.frame = f[2:0];
		r.faults = fault_tally;
		r.accesses = access_tally;
		return r;
	endfunction

	function automatic void cmp(input string fname, input longint unsigned want,
		input longint unsigned got);
		if (want != got) begin
			$display("%0t %s mismatch: expected %0h, actual %0h", $time, fname, want, got);
			errors++;
		end
	endfunction

	// call at a falling edge; returns at the falling edge after the word is taken
	task automatic offer(input logic [7:0] pg, input logic wr, input logic fixed,
		input access_result_t want);
		int gap;
		access_result_t r;
		gap = quiet ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			acc_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		acc_ch.valid <= 1'b1;
		acc_ch.page_id <= pg;
		acc_ch.is_write <= wr;
		do @(posedge clk); while (!acc_ch.ready);
		r = predict_access(pg, wr);
		case (r.outcome)
			ecpr_pkg::OUTCOME_PRELOAD: n_pre++;
			ecpr_pkg::OUTCOME_HIT:     n_hit++;
			default:                   n_fault++;
		endcase
		if (r.ev_valid) n_evict++;
		awaited_outcomes.push_back(fixed ? want : r);
		@(negedge clk);
	endtask

	task automatic drain();
		acc_ch.valid <= 1'b0;
		while (awaited_outcomes.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [ecpr_pkg::CFG_INDEX_BITS-1:0] idx,
		input logic [3:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == ecpr_pkg::CFG_FRAMES_IN_USE) cfg_frames = val;
		else cfg_preload = val;
		n_reg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (awaited_outcomes.size() == 0) begin
				$display("%0t unexpected result: expected none, actual outcome %0d frame %0d",
					$time, res_ch.outcome, res_ch.frame);
				errors++;
			end else begin
				oldest = awaited_outcomes.pop_front();
				cmp("outcome", oldest.outcome, res_ch.outcome);
				cmp("frame", oldest.frame, res_ch.frame);
				cmp("evicted_valid", oldest.ev_valid, res_ch.evicted_valid);
				cmp("evicted_page", oldest.ev_page, res_ch.evicted_page);
				cmp("fault_count", oldest.faults, res_ch.fault_count);
				cmp("access_count", oldest.accesses, res_ch.access_count);
			end
		end
	end

	always @(posedge clk) begin
		if ((acc_ch.valid && acc_ch.ready) || (res_ch.valid && res_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		while (stall_cycles < STALL_LIMIT) @(posedge clk);
		$display("%0t watchdog: no word moved for %0d cycles", $time, STALL_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	// result side: random ready gaps, one long hold-off on request
	initial begin
		int gap;
		res_ch.ready = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_req) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			gap = quiet ? 0 : $urandom_range(0, 16);
			if (gap != 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
			@(negedge clk);
		end
	end

	initial begin
		int fv, span;
		logic [7:0] hot_base, pg;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = ecpr_pkg::CFG_FRAMES_IN_USE;
		cfg_data = '0;
		acc_ch.valid = 1'b0;
		acc_ch.page_id = '0;
		acc_ch.is_write = 1'b0;
		errors = 0;
		stall_cycles = 0;
		quiet = 1'b0;
		hold_req = 1'b0;
		n_pre = 0;
		n_hit = 0;
		n_fault = 0;
		n_evict = 0;
		n_reg_writes = 0;
		for (int i = 0; i < FRAMES; i++) begin
			frame_pg[i] = '0;
			frame_live[i] = 1'b0;
			a_bit[i] = 1'b0;
			m_bit[i] = 1'b0;
		end
		fill_level = 0;
		hand_pos = 0;
		fault_tally = '0;
		access_tally = '0;
		cfg_frames = ecpr_pkg::FRAMES_IN_USE_RESET;
		cfg_preload = ecpr_pkg::PRELOAD_COUNT_RESET;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIR_ROWS[r]) begin
			case (DIR_ROWS[r].kind)
				ROW_SET_FRAMES: begin
					drain();
					write_reg(ecpr_pkg::CFG_FRAMES_IN_USE, DIR_ROWS[r].val[3:0]);
				end
				ROW_SET_PRELOAD: begin
					drain();
					write_reg(ecpr_pkg::CFG_PRELOAD_COUNT, DIR_ROWS[r].val[3:0]);
				end
				default: offer(DIR_ROWS[r].val, DIR_ROWS[r].wr, DIR_ROWS[r].fixed,
					DIR_ROWS[r].want);
			endcase
		end

		for (int seg = 0; seg < 11; seg++) begin
			drain();
			fv = (seg == 0) ? 8 : (seg == 1) ? 1 : (seg == 4) ? 2 : $urandom_range(0, 15);
			write_reg(ecpr_pkg::CFG_FRAMES_IN_USE, fv[3:0]);
			write_reg(ecpr_pkg::CFG_PRELOAD_COUNT, 4'($urandom_range(0, 15)));
			span = ((fv == 0) ? 1 : (fv > FRAMES) ? FRAMES : fv) + 2;
			quiet = (seg == 2 || seg == 7);
			if (seg == 3) hold_req = 1'b1;
			hot_base = 8'($urandom_range(0, 255));
			for (int k = 0; k < 150; k++) begin
				if (seg == 5 && k == 75) drain();
				if ($urandom_range(0, 3) != 0) pg = hot_base + 8'($urandom_range(0, span));
				else pg = 8'($urandom);
				if ($urandom_range(0, 31) == 0) hot_base = 8'($urandom_range(0, 255));
				offer(pg, 1'($urandom_range(0, 1)), 1'b0, '0);
			end
		end
		quiet = 1'b0;

		drain();
		repeat (20) @(negedge clk);
		if (awaited_outcomes.size() != 0) begin
			$display("%0t %0d results never arrived", $time, awaited_outcomes.size());
			errors++;
		end
		$display("covered %0d preloads, %0d hits, %0d faults (%0d with eviction)",
			n_pre, n_hit, n_fault, n_evict);
		$display("across %0d register writes, ready gaps, one long hold-off; %0d errors",
			n_reg_writes, errors);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
